// ----- hw/rtl/isrs_pkg.sv -----
`default_nettype none

package isrs_pkg;

    // Size field width and derived datapath widths
    localparam int SIZE_BITS       = 12;
    localparam int MAX_SHIFT       = 5;                 // pre-scale ratio up to 32
    localparam int LIMIT_SHIFT     = 6;                 // source >= 64 * target is out of range
    localparam int DIV_W           = SIZE_BITS + MAX_SHIFT;
    localparam int REM_W           = SIZE_BITS + LIMIT_SHIFT;
    localparam int SHIFT_W         = 3;
    localparam int RATIO_W         = 6;
    localparam int FRAC_BITS       = 8;
    localparam int QUOT_W          = FRAC_BITS + 1;
    localparam int SUM_W           = 4;
    localparam int SHIFT_SUM_BASE  = 10;
    localparam int STEPS_PER_STAGE = 3;                 // QUOT_W / 3 division stages
    localparam int STATUS_W        = 2;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_ZERO  = 2'd1,
        STATUS_RANGE = 2'd2
    } status_t;

    // Per-axis result of the pre-scale ratio search
    typedef struct packed {
        logic [SHIFT_W-1:0] shift;
        logic               too_big;
        logic               upscale;
    } pick_t;

    // Per-axis state carried through the divider stages
    typedef struct packed {
        logic [DIV_W-1:0]     div;
        logic [REM_W-1:0]     rem;
        logic [QUOT_W-1:0]    quot;
        logic [SHIFT_W-1:0]   shift;
        logic [SIZE_BITS-1:0] pre_out;
        logic                 upscale;
    } axis_t;

    typedef struct packed {
        status_t           status;
        axis_t             h;
        axis_t             v;
        logic [SUM_W-1:0]  shift_sum;
    } stage_t;

    // Restoring division: STEPS_PER_STAGE quotient bits, MSB first.
    // Invariant: rem < 2 * div on entry to each step.
    function automatic axis_t div_advance(axis_t a);
        axis_t r;
        logic  q;
        r = a;
        for (int i = 0; i < STEPS_PER_STAGE; i++) begin
            q = (r.rem >= REM_W'(r.div));
            r.quot = {r.quot[QUOT_W-2:0], q};
            r.rem  = q ? ((r.rem - REM_W'(r.div)) << 1) : (r.rem << 1);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/image_scaler_ratio_setup.sv -----
// Throughput: one item per cycle unless the output is stalled with every stage
//   full; a four-stage pipeline (ratio search, then three stages of a restoring
//   divider at 3 quotient bits each).
// Each stage holds its item until the next stage frees, so bubbles fill in
//   while the output is stalled.
// Reset (rst_n low, asynchronous) empties the pipeline; the payload registers are not reset.
`default_nettype none

module image_scaler_ratio_setup
    import isrs_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [11:0] source_width, [23:12] source_height,
    // [35:24] target_width, [47:36] target_height
    input  wire logic [47:0] s_tdata,

    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [1:0] status, [7:2] pre_h_ratio, [13:8] pre_v_ratio, [16:14] h_shift,
    // [19:17] v_shift, [31:20] pre_out_width, [43:32] pre_out_height,
    // [52:44] main_h_ratio, [61:53] main_v_ratio, [62] upscale_h,
    // [63] upscale_v, [67:64] shift_sum, [71:68] zero
    output logic [71:0]      m_tdata
);

    localparam int FIELD_BITS = STATUS_W + 2 * RATIO_W + 2 * SHIFT_W + 2 * SIZE_BITS
                              + 2 * QUOT_W + 2 + SUM_W;
    localparam int PAD_BITS   = 72 - FIELD_BITS;

    // ---------------------------------------------------------------------
    // Input unpack
    // ---------------------------------------------------------------------
    logic [SIZE_BITS-1:0] source_width;
    logic [SIZE_BITS-1:0] source_height;
    logic [SIZE_BITS-1:0] target_width;
    logic [SIZE_BITS-1:0] target_height;

    assign source_width  = s_tdata[SIZE_BITS-1:0];
    assign source_height = s_tdata[2*SIZE_BITS-1:SIZE_BITS];
    assign target_width  = s_tdata[3*SIZE_BITS-1:2*SIZE_BITS];
    assign target_height = s_tdata[4*SIZE_BITS-1:3*SIZE_BITS];

    // ---------------------------------------------------------------------
    // Stage flow control: each stage loads when empty or when it drains
    // ---------------------------------------------------------------------
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic rdy1, rdy2, rdy3, rdy4;

    assign rdy4     = !v4_reg || m_tready;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign s_tready = rdy1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (rdy1) v1_reg <= s_tvalid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
        end
    end

    // ---------------------------------------------------------------------
    // Stage 1: pre-scale ratio search, error checks, divider setup
    // ---------------------------------------------------------------------
    pick_t  pick_h, pick_v;
    stage_t st1_next, st1_reg;

    isrs_shift_pick u_pick_h
    (
        .src  (source_width),
        .tar  (target_width),
        .pick (pick_h)
    );

    isrs_shift_pick u_pick_v
    (
        .src  (source_height),
        .tar  (target_height),
        .pick (pick_v)
    );

    always_comb
    begin
        logic               any_zero;
        logic [SHIFT_W-1:0] hs;
        logic [SHIFT_W-1:0] vs;

        any_zero = (target_width == '0) || (target_height == '0)
                || (source_width == '0) || (source_height == '0);

        priority if (any_zero)
        begin
            st1_next.status = STATUS_ZERO;
        end
        else if (pick_h.too_big || pick_v.too_big)
        begin
            st1_next.status = STATUS_RANGE;
        end
        else
        begin
            st1_next.status = STATUS_OK;
        end

        // error results are zeroed at the output; keep shifts benign meanwhile
        hs = (st1_next.status == STATUS_OK) ? pick_h.shift : '0;
        vs = (st1_next.status == STATUS_OK) ? pick_v.shift : '0;

        st1_next.h.div     = DIV_W'(target_width) << hs;
        st1_next.h.rem     = REM_W'(source_width);
        st1_next.h.quot    = '0;
        st1_next.h.shift   = hs;
        st1_next.h.pre_out = source_width >> hs;
        st1_next.h.upscale = pick_h.upscale;

        st1_next.v.div     = DIV_W'(target_height) << vs;
        st1_next.v.rem     = REM_W'(source_height);
        st1_next.v.quot    = '0;
        st1_next.v.shift   = vs;
        st1_next.v.pre_out = source_height >> vs;
        st1_next.v.upscale = pick_v.upscale;

        st1_next.shift_sum = SUM_W'(SHIFT_SUM_BASE) - SUM_W'(hs) - SUM_W'(vs);
    end

    // ---------------------------------------------------------------------
    // Stages 2 and 3: quotient bits 8..6 and 5..3
    // ---------------------------------------------------------------------
    stage_t st2_next, st2_reg;
    stage_t st3_next, st3_reg;

    always_comb
    begin
        st2_next   = st1_reg;
        st2_next.h = div_advance(st1_reg.h);
        st2_next.v = div_advance(st1_reg.v);

        st3_next   = st2_reg;
        st3_next.h = div_advance(st2_reg.h);
        st3_next.v = div_advance(st2_reg.v);
    end

    // ---------------------------------------------------------------------
    // Stage 4: quotient bits 2..0 and result formatting (output register)
    // ---------------------------------------------------------------------
    logic [71:0] m_tdata_next, m_tdata_reg;

    always_comb
    begin
        axis_t fh;
        axis_t fv;
        logic  ok;

        fh = div_advance(st3_reg.h);
        fv = div_advance(st3_reg.v);
        ok = (st3_reg.status == STATUS_OK);

        if (ok)
        begin
            m_tdata_next = {
                PAD_BITS'(0),
                st3_reg.shift_sum,
                fv.upscale,
                fh.upscale,
                fv.quot,
                fh.quot,
                fv.pre_out,
                fh.pre_out,
                fv.shift,
                fh.shift,
                RATIO_W'(1) << fv.shift,
                RATIO_W'(1) << fh.shift,
                st3_reg.status
            };
        end
        else
        begin
            m_tdata_next = {(72 - STATUS_W)'(0), st3_reg.status};
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (rdy1) st1_reg     <= st1_next;
        if (rdy2) st2_reg     <= st2_next;
        if (rdy3) st3_reg     <= st3_next;
        if (rdy4) m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = v4_reg;
    assign m_tdata  = m_tdata_reg;

    // ---------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------
    // input side only stalls when every stage is full and the output is held
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (v1_reg && v2_reg && v3_reg && m_tvalid && !m_tready))
        else $error("input stalled with a free pipeline slot");

    // error results carry nothing but the status
    a_error_zeroed: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[1:0] != STATUS_OK) |-> (m_tdata[71:2] == '0))
        else $error("error result has nonzero fields");

    // pre-scale ratio matches its shift on both axes
    a_ratio_matches_shift: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[1:0] == STATUS_OK) |->
            (m_tdata[7:2] == (RATIO_W'(1) << m_tdata[16:14]))
            && (m_tdata[13:8] == (RATIO_W'(1) << m_tdata[19:17])))
        else $error("pre-scale ratio and shift disagree");

    // shift sum consistent with the reported shifts
    a_shift_sum: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[1:0] == STATUS_OK) |->
            (m_tdata[67:64] == SUM_W'(SHIFT_SUM_BASE) - SUM_W'(m_tdata[16:14])
                                - SUM_W'(m_tdata[19:17])))
        else $error("shift sum mismatch");

endmodule

`default_nettype wire

// ----- hw/rtl/isrs_shift_pick.sv -----
`default_nettype none

module isrs_shift_pick
    import isrs_pkg::*;
(
    input  wire logic [SIZE_BITS-1:0] src,
    input  wire logic [SIZE_BITS-1:0] tar,
    output pick_t                     pick
);

    logic [REM_W-1:0] src_ext;

    assign src_ext = REM_W'(src);

    // Largest s in 1..MAX_SHIFT with src >= tar << s, else 0; compares are independent
    always_comb
    begin
        pick.shift   = '0;
        pick.too_big = (src_ext >= (REM_W'(tar) << LIMIT_SHIFT));
        pick.upscale = (tar >= src);
        for (int s = 1; s <= MAX_SHIFT; s++) begin
            if (src_ext >= (REM_W'(tar) << s))
            begin
                pick.shift = SHIFT_W'(s);
            end
        end
    end

endmodule

`default_nettype wire

// ----- test/tb_image_scaler_ratio_setup.sv -----
`default_nettype none

module tb_image_scaler_ratio_setup
    import isrs_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    // Expected master-side transfer, one per accepted size request.
    typedef struct packed {
        status_t              status;
        logic [RATIO_W-1:0]   pre_h_ratio;
        logic [RATIO_W-1:0]   pre_v_ratio;
        logic [SHIFT_W-1:0]   h_shift;
        logic [SHIFT_W-1:0]   v_shift;
        logic [SIZE_BITS-1:0] pre_out_width;
        logic [SIZE_BITS-1:0] pre_out_height;
        logic [QUOT_W-1:0]    main_h_ratio;
        logic [QUOT_W-1:0]    main_v_ratio;
        logic                 upscale_h;
        logic                 upscale_v;
        logic [SUM_W-1:0]     shift_sum;
    } scaler_setup_t;

    // Holds the scaler settings still owed by the block, oldest first, and
    // grades each result against them.
    class setup_scoreboard;
        scaler_setup_t owed_setups[$];
        int mismatches;
        int results_checked;
        int n_ok;
        int n_zero;
        int n_range;
        int n_pow2_boundary;

        function new();
            mismatches      = 0;
            results_checked = 0;
            n_ok            = 0;
            n_zero          = 0;
            n_range         = 0;
            n_pow2_boundary = 0;
        endfunction

        // Largest s in 0..5 with src >= tgt << s; LIMIT_SHIFT flags out of range.
        function int prescale_shift(int src, int tgt);
            if (src >= tgt * 64)
                return LIMIT_SHIFT;
            for (int s = MAX_SHIFT; s > 0; s--)
                if (src >= (tgt << s))
                    return s;
            return 0;
        endfunction

        function scaler_setup_t predict_setup(logic [47:0] req);
            int sw;
            int sh;
            int tw;
            int th;
            int hs;
            int vs;
            scaler_setup_t r;
            sw = req[11:0];
            sh = req[23:12];
            tw = req[35:24];
            th = req[47:36];
            r  = '0;
            // zero size wins over the range check
            if (tw == 0 || th == 0 || sw == 0 || sh == 0) begin
                r.status = STATUS_ZERO;
                return r;
            end
            hs = prescale_shift(sw, tw);
            vs = prescale_shift(sh, th);
            if (hs > MAX_SHIFT || vs > MAX_SHIFT) begin
                r.status = STATUS_RANGE;
                return r;
            end
            r.status         = STATUS_OK;
            r.pre_h_ratio    = RATIO_W'(1 << hs);
            r.pre_v_ratio    = RATIO_W'(1 << vs);
            r.h_shift        = SHIFT_W'(hs);
            r.v_shift        = SHIFT_W'(vs);
            r.pre_out_width  = SIZE_BITS'(sw >> hs);
            r.pre_out_height = SIZE_BITS'(sh >> vs);
            r.main_h_ratio   = QUOT_W'((sw << FRAC_BITS) / (tw << hs));
            r.main_v_ratio   = QUOT_W'((sh << FRAC_BITS) / (th << vs));
            r.upscale_h      = (tw >= sw);
            r.upscale_v      = (th >= sh);
            r.shift_sum      = SUM_W'(SHIFT_SUM_BASE - hs - vs);
            return r;
        endfunction

        function void note_request(logic [47:0] req);
            scaler_setup_t e;
            e = predict_setup(req);
            case (e.status)
                STATUS_ZERO:  n_zero++;
                STATUS_RANGE: n_range++;
                default:      n_ok++;
            endcase
            // source exactly on a ratio step on either axis
            if (e.status == STATUS_OK &&
                (req[11:0] == (req[35:24] << e.h_shift) ||
                 req[23:12] == (req[47:36] << e.v_shift)))
                n_pow2_boundary++;
            owed_setups.push_back(e);
        endfunction

        function int pending();
            return owed_setups.size();
        endfunction

        // One line per mismatch; printing stops after a while, counting does not.
        task report(string what);
            mismatches++;
            if (mismatches <= 40)
                $display("%0t ns  mismatch: %s", $time, what);
        endtask

        task cmp_field(string name, longint unsigned got, longint unsigned want);
            if (got !== want)
                report($sformatf("%s got %0d expected %0d", name, got, want));
        endtask

        task check_result(logic [71:0] d);
            scaler_setup_t e;
            if (owed_setups.size() == 0) begin
                report($sformatf("result %h with nothing pending", d));
                return;
            end
            e = owed_setups.pop_front();
            results_checked++;
            cmp_field("status",         d[1:0],   e.status);
            cmp_field("pre_h_ratio",    d[7:2],   e.pre_h_ratio);
            cmp_field("pre_v_ratio",    d[13:8],  e.pre_v_ratio);
            cmp_field("h_shift",        d[16:14], e.h_shift);
            cmp_field("v_shift",        d[19:17], e.v_shift);
            cmp_field("pre_out_width",  d[31:20], e.pre_out_width);
            cmp_field("pre_out_height", d[43:32], e.pre_out_height);
            cmp_field("main_h_ratio",   d[52:44], e.main_h_ratio);
            cmp_field("main_v_ratio",   d[61:53], e.main_v_ratio);
            cmp_field("upscale_h",      d[62],    e.upscale_h);
            cmp_field("upscale_v",      d[63],    e.upscale_v);
            cmp_field("shift_sum",      d[67:64], e.shift_sum);
            cmp_field("pad bits",       d[71:68], 0);
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    // [11:0] source_width, [23:12] source_height,
    // [35:24] target_width, [47:36] target_height
    logic [47:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    // [1:0] status, [7:2] pre_h_ratio, [13:8] pre_v_ratio, [16:14] h_shift,
    // [19:17] v_shift, [31:20] pre_out_width, [43:32] pre_out_height,
    // [52:44] main_h_ratio, [61:53] main_v_ratio, [62] upscale_h,
    // [63] upscale_v, [67:64] shift_sum, [71:68] zero
    logic [71:0] m_tdata;

    setup_scoreboard sb;
    bit              gaps_on;     // sender idles between transfers
    bit              stalls_on;   // receiver holds m_tready low at times
    int              sent;

    image_scaler_ratio_setup DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop: far beyond the slowest legal run (~1500 items, each with
    // the longest sender gap and receiver stall plus pipeline latency).
    initial
    begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

    // Inputs change on the falling edge; a transfer counts at the rising
    // edge where s_tvalid and s_tready are both high.
    task send_sizes(int sw, int sh, int tw, int th);
        logic [47:0] req;
        int          gap;
        req = {12'(th), 12'(tw), 12'(sh), 12'(sw)};
        gap = gaps_on ? $urandom_range(0, 17) : 0;
        repeat (gap)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= req;
        do @(posedge clk); while (!s_tready);
        sb.note_request(req);
        sent++;
    endtask

    task wait_drained();
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // One axis of a random request. Mostly a target plus a source that lands
    // in a chosen pre-scale band, often right on a band edge; some upscale,
    // some out of range, some raw noise.
    task gen_axis(output int src, output int tgt);
        int kind;
        int k;
        int lo;
        int hi;
        kind = $urandom_range(0, 99);
        if (kind < 8)
        begin
            src = $urandom_range(0, 4095);
            tgt = $urandom_range(0, 4095);
            return;
        end
        tgt = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 63) : $urandom_range(1, 4095);
        if (kind < 18)
        begin
            src = $urandom_range(1, tgt);           // upscale
            return;
        end
        k  = ($urandom_range(0, 11) == 0) ? LIMIT_SHIFT : $urandom_range(0, MAX_SHIFT);
        lo = tgt << k;
        if (lo > 4095)
        begin
            src = $urandom_range(1, 4095);
            return;
        end
        hi = (2 * lo - 1 > 4095) ? 4095 : 2 * lo - 1;
        if (k == LIMIT_SHIFT)
            hi = 4095;
        case ($urandom_range(0, 3))
            0:       src = lo;
            1:       src = lo - 1;
            default: src = $urandom_range(lo, hi);
        endcase
    endtask

    // Result side: random stalls, sampled at the rising edge.
    initial
    begin
        int stall;
        int taken;
        taken = 0;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = stalls_on ? $urandom_range(0, 17) : 0;
            repeat (stall)
            begin
                @(negedge clk);
                m_tready <= 1'b0;
            end
            @(negedge clk);
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            sb.check_result(m_tdata);
            taken++;
            if (taken % 137 == 0)
                stalls_on = ($urandom_range(0, 3) != 0);
        end
    end

    initial
    begin
        int sw;
        int sh;
        int tw;
        int th;
        sb        = new();
        sent      = 0;
        gaps_on   = 1'b1;
        stalls_on = 1'b1;
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: zero sizes on each field, zero beating out of range,
        // range limit on each axis, every shift value, extremes.
        send_sizes(0, 0, 0, 0);
        send_sizes(0, 100, 100, 100);
        send_sizes(100, 0, 100, 100);
        send_sizes(100, 100, 0, 100);
        send_sizes(100, 100, 100, 0);
        send_sizes(64, 0, 1, 1);            // zero wins over range
        send_sizes(64, 10, 1, 10);          // horizontal exactly 64x
        send_sizes(10, 64, 10, 1);          // vertical exactly 64x
        send_sizes(4095, 4095, 1, 1);
        send_sizes(1, 4095, 4095, 1);
        send_sizes(63, 63, 1, 1);           // shift 5, main ratio 504
        send_sizes(4095, 4095, 64, 64);     // shift 5, main ratio 511
        send_sizes(4095, 4095, 4095, 4095);
        send_sizes(1, 1, 4095, 4095);       // upscale both
        send_sizes(1, 1, 1, 1);
        send_sizes(2, 4, 1, 1);             // shifts 1 and 2 on the edge
        send_sizes(8, 16, 1, 1);            // shifts 3 and 4 on the edge
        send_sizes(3, 7, 2, 2);
        send_sizes(2047, 1023, 1024, 512);  // shift 0, ratio just under 2
        send_sizes(4095, 2047, 128, 1024);
        send_sizes(4032, 4031, 63, 63);
        send_sizes(2730, 1365, 2731, 1364);
        @(negedge clk);
        s_tvalid <= 1'b0;
        wait_drained();                     // pause with everything returned

        while (sent < 1472)
        begin
            if (sent % 173 == 0)
                gaps_on = ($urandom_range(0, 3) != 0);
            if (sent == 800)
            begin
                @(negedge clk);
                s_tvalid <= 1'b0;
                wait_drained();
            end
            gen_axis(sw, tw);
            gen_axis(sh, th);
            send_sizes(sw, sh, tw, th);
        end
        @(negedge clk);
        s_tvalid <= 1'b0;

        wait_drained();
        repeat (20) @(posedge clk);         // catch any stray result

        $display("Covered %0d size requests: %0d valid, %0d zero size, %0d out of range.",
                 sent, sb.n_ok, sb.n_zero, sb.n_range);
        $display("%0d results graded, %0d with a source on a ratio step; %0d mismatches.",
                 sb.results_checked, sb.n_pow2_boundary, sb.mismatches);
        if (sb.mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

`default_nettype wire

// ----- files.f -----
hw/rtl/isrs_pkg.sv
hw/rtl/isrs_shift_pick.sv
hw/rtl/image_scaler_ratio_setup.sv
test/tb_image_scaler_ratio_setup.sv
